/* hdl/lcfcd_pkg.sv */
// Package for the low-current full-charge detector.
// Holds sizing constants, codes and shared structs; no dependencies.
package lcfcd_pkg;

  localparam int NUM_REGIONS      = 6;
  localparam int PAIRS_PER_REGION = 6;
  localparam int PAIR_SLOTS       = NUM_REGIONS * PAIRS_PER_REGION;

  localparam int REGION_W    = $clog2(NUM_REGIONS + 1);
  localparam int RIDX_W      = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int THR_IDX_W   = $clog2(NUM_REGIONS + 1);
  localparam int PAIR_CNT_W  = $clog2(PAIRS_PER_REGION + 1);
  localparam int PAIR_ADDR_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

  localparam int ACTION_W  = 3;
  localparam int TEMP_W    = 12;
  localparam int VOLT_W    = 16;
  localparam int CURR_W    = 16;
  localparam int FIELD3_W  = 3;
  localparam int LIMIT_W   = 4;
  localparam int CMP_W     = 17;
  localparam int PAIR_W    = CURR_W + VOLT_W;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET = 4'd2;
  localparam logic [LIMIT_W-1:0] HIT_RESET      = 4'd6;
  localparam logic [LIMIT_W-1:0] COUNT_MAX      = 4'hF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE    = 3'd0,
    ACT_START     = 3'd1,
    ACT_WR_THRESH = 3'd2,
    ACT_WR_PAIR   = 3'd3,
    ACT_WR_COUNT  = 3'd4
  } action_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_HIT      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REGION,
    S_DECIDE,
    S_PAIR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [TEMP_W-1:0] temperature;
    logic [VOLT_W-1:0]        cell_voltage;
    logic signed [CURR_W-1:0] cell_current;
    logic [FIELD3_W-1:0]      table_region;
    logic [FIELD3_W-1:0]      table_slot;
    logic [FIELD3_W-1:0]      pair_count;
  } item_t;

  typedef struct packed {
    logic                full_flag;
    logic                status_code;
    logic [FIELD3_W-1:0] region_in_use;
  } result_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] region_debounce_limit;
    logic [LIMIT_W-1:0] full_hit_limit;
  } cfg_t;

endpackage

/* hdl/lcfcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcfcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lcfcd_cmp.sv */
// Shared two-lane signed less-or-equal comparator.
// Depends on lcfcd_pkg.
module lcfcd_cmp (
  input  logic signed [lcfcd_pkg::CMP_W-1:0] a0,
  input  logic signed [lcfcd_pkg::CMP_W-1:0] b0,
  input  logic signed [lcfcd_pkg::CMP_W-1:0] a1,
  input  logic signed [lcfcd_pkg::CMP_W-1:0] b1,
  output logic [1:0]                         le
);

  assign le[0] = (a0 <= b0);
  assign le[1] = (a1 <= b1);

endmodule

/* hdl/lcfcd_seq.sv */
// Sequencer and datapath: stores, threshold walk, debounce and pair walk.
// Depends on lcfcd_pkg, lcfcd_cmp and lcfcd_ram.
module lcfcd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  lcfcd_pkg::cfg_t    cfg,
  input  logic               item_valid,
  input  lcfcd_pkg::item_t   item,
  output logic               item_ready,
  output logic               res_valid,
  output lcfcd_pkg::result_t res,
  input  logic               res_ready
);

  lcfcd_pkg::state_t state_r, state_nxt;
  lcfcd_pkg::item_t  item_r;

  logic signed [lcfcd_pkg::TEMP_W-1:0] thr_r [lcfcd_pkg::NUM_REGIONS+1];
  logic [lcfcd_pkg::FIELD3_W-1:0]      pc_r  [lcfcd_pkg::NUM_REGIONS];

  logic [lcfcd_pkg::REGION_W-1:0]    last_r, sreg_r, found_reg_r;
  logic [lcfcd_pkg::LIMIT_W-1:0]     mc_r, hc_r;
  logic [lcfcd_pkg::THR_IDX_W-1:0]   k_r;
  logic                              found_r, prev_ge_r;
  logic [lcfcd_pkg::PAIR_CNT_W-1:0]  j_r, n_r;
  logic [lcfcd_pkg::PAIR_ADDR_W-1:0] base_r;
  logic                              rd_v_r, rd_last_r, hit_r;
  lcfcd_pkg::result_t                res_r;

  logic signed [lcfcd_pkg::CMP_W-1:0] a0, b0, a1, b1;
  logic [1:0]                         le;
  logic                               issue;
  logic                               ram_we;
  logic [lcfcd_pkg::PAIR_ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [lcfcd_pkg::PAIR_W-1:0]       ram_rdata;
  logic signed [lcfcd_pkg::CURR_W-1:0] clim;
  logic [lcfcd_pkg::VOLT_W-1:0]        vlim;

  logic [lcfcd_pkg::LIMIT_W-1:0]     mc_inc;
  logic [lcfcd_pkg::REGION_W-1:0]    sreg_new;
  logic                              adopt, mismatch;
  logic [lcfcd_pkg::FIELD3_W-1:0]    pc_sel;
  logic [lcfcd_pkg::PAIR_CNT_W-1:0]  n_new;
  logic                              hit_now, hit_fin;
  logic [lcfcd_pkg::LIMIT_W:0]       hc_inc;

  assign clim = ram_rdata[lcfcd_pkg::PAIR_W-1:lcfcd_pkg::VOLT_W];
  assign vlim = ram_rdata[lcfcd_pkg::VOLT_W-1:0];

  lcfcd_cmp u_cmp (
    .a0 (a0),
    .b0 (b0),
    .a1 (a1),
    .b1 (b1),
    .le (le)
  );

  lcfcd_ram #(
    .WIDTH (lcfcd_pkg::PAIR_W),
    .DEPTH (lcfcd_pkg::PAIR_SLOTS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item_r.cell_current, item_r.cell_voltage}),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state_r == lcfcd_pkg::S_PAIR) begin
      a0 = lcfcd_pkg::CMP_W'(item_r.cell_current);
      b0 = lcfcd_pkg::CMP_W'(clim);
      a1 = $signed({1'b0, vlim});
      b1 = $signed({1'b0, item_r.cell_voltage});
    end else begin
      a0 = lcfcd_pkg::CMP_W'(thr_r[k_r]);
      b0 = lcfcd_pkg::CMP_W'(item_r.temperature);
      a1 = '0;
      b1 = '0;
    end
  end

  always_comb begin
    mismatch = (found_reg_r != last_r);
    mc_inc   = (mc_r != lcfcd_pkg::COUNT_MAX) ? mc_r + 1'b1 : mc_r;
    adopt    = mismatch && (mc_inc >= cfg.region_debounce_limit);
    sreg_new = adopt ? found_reg_r : sreg_r;
    pc_sel   = pc_r[sreg_new[lcfcd_pkg::RIDX_W-1:0]];
    if (32'(pc_sel) > lcfcd_pkg::PAIRS_PER_REGION) begin
      n_new = lcfcd_pkg::PAIR_CNT_W'(lcfcd_pkg::PAIRS_PER_REGION);
    end else begin
      n_new = lcfcd_pkg::PAIR_CNT_W'(pc_sel);
    end
    hit_now = le[0] && le[1];
    hit_fin = hit_r || hit_now;
    hc_inc  = {1'b0, hc_r} + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcfcd_pkg::S_IDLE: begin
        if (item_valid) begin
          state_nxt = lcfcd_pkg::S_EXEC;
        end
      end
      lcfcd_pkg::S_EXEC: begin
        if (item_r.action inside {lcfcd_pkg::ACT_SAMPLE, lcfcd_pkg::ACT_START}) begin
          state_nxt = lcfcd_pkg::S_REGION;
        end else begin
          state_nxt = lcfcd_pkg::S_DONE;
        end
      end
      lcfcd_pkg::S_REGION: begin
        if (32'(k_r) == lcfcd_pkg::NUM_REGIONS) begin
          state_nxt = lcfcd_pkg::S_DECIDE;
        end
      end
      lcfcd_pkg::S_DECIDE: begin
        if (item_r.action == lcfcd_pkg::ACT_SAMPLE &&
            32'(sreg_new) < lcfcd_pkg::NUM_REGIONS && n_new != '0) begin
          state_nxt = lcfcd_pkg::S_PAIR;
        end else begin
          state_nxt = lcfcd_pkg::S_DONE;
        end
      end
      lcfcd_pkg::S_PAIR: begin
        if (rd_v_r && rd_last_r) begin
          state_nxt = lcfcd_pkg::S_DONE;
        end
      end
      lcfcd_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = lcfcd_pkg::S_IDLE;
        end
      end
      default: state_nxt = lcfcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state_r == lcfcd_pkg::S_IDLE);
    res_valid  = (state_r == lcfcd_pkg::S_DONE);
    issue      = (state_r == lcfcd_pkg::S_PAIR) && (j_r < n_r);
    ram_raddr  = base_r + lcfcd_pkg::PAIR_ADDR_W'(j_r);
    ram_waddr  = lcfcd_pkg::PAIR_ADDR_W'(item_r.table_region * lcfcd_pkg::PAIRS_PER_REGION
                                         + item_r.table_slot);
    ram_we     = (state_r == lcfcd_pkg::S_EXEC) &&
                 (item_r.action == lcfcd_pkg::ACT_WR_PAIR) &&
                 (32'(item_r.table_region) < lcfcd_pkg::NUM_REGIONS) &&
                 (32'(item_r.table_slot) < lcfcd_pkg::PAIRS_PER_REGION);
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcfcd_pkg::S_IDLE;
      last_r  <= lcfcd_pkg::REGION_W'(lcfcd_pkg::NUM_REGIONS);
      sreg_r  <= lcfcd_pkg::REGION_W'(lcfcd_pkg::NUM_REGIONS);
      mc_r    <= '0;
      hc_r    <= '0;
      rd_v_r  <= 1'b0;
      for (int i = 0; i < lcfcd_pkg::NUM_REGIONS; i++) begin
        pc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      case (state_r)
        lcfcd_pkg::S_IDLE: begin
          if (item_valid) begin
            item_r <= item;
          end
        end
        lcfcd_pkg::S_EXEC: begin
          k_r         <= '0;
          found_r     <= 1'b0;
          prev_ge_r   <= 1'b0;
          found_reg_r <= lcfcd_pkg::REGION_W'(lcfcd_pkg::NUM_REGIONS);
          res_r.full_flag     <= 1'b0;
          res_r.status_code   <= 1'b0;
          res_r.region_in_use <= lcfcd_pkg::FIELD3_W'(sreg_r);
          case (item_r.action)
            lcfcd_pkg::ACT_WR_THRESH: begin
              if (32'(item_r.table_slot) <= lcfcd_pkg::NUM_REGIONS) begin
                thr_r[lcfcd_pkg::THR_IDX_W'(item_r.table_slot)] <= item_r.temperature;
              end
            end
            lcfcd_pkg::ACT_WR_COUNT: begin
              if (32'(item_r.table_region) < lcfcd_pkg::NUM_REGIONS) begin
                pc_r[lcfcd_pkg::RIDX_W'(item_r.table_region)] <= item_r.pair_count;
              end
            end
            default: ;
          endcase
        end
        lcfcd_pkg::S_REGION: begin
          prev_ge_r <= le[0];
          k_r       <= k_r + 1'b1;
          if (k_r != '0 && !found_r && prev_ge_r && !le[0]) begin
            found_r     <= 1'b1;
            found_reg_r <= lcfcd_pkg::REGION_W'(k_r - 1'b1);
          end
        end
        lcfcd_pkg::S_DECIDE: begin
          j_r    <= '0;
          n_r    <= n_new;
          hit_r  <= 1'b0;
          base_r <= lcfcd_pkg::PAIR_ADDR_W'(sreg_new * lcfcd_pkg::PAIRS_PER_REGION);
          if (item_r.action == lcfcd_pkg::ACT_START) begin
            sreg_r <= found_reg_r;
            hc_r   <= '0;
            res_r.region_in_use <= lcfcd_pkg::FIELD3_W'(found_reg_r);
          end else begin
            if (mismatch) begin
              mc_r <= adopt ? '0 : mc_inc;
            end
            if (adopt) begin
              last_r <= found_reg_r;
              sreg_r <= found_reg_r;
            end
            res_r.region_in_use <= lcfcd_pkg::FIELD3_W'(sreg_new);
            if (32'(sreg_new) >= lcfcd_pkg::NUM_REGIONS) begin
              res_r.status_code <= 1'b1;
            end else if (n_new == '0) begin
              hc_r <= '0;
            end
          end
        end
        lcfcd_pkg::S_PAIR: begin
          if (issue) begin
            j_r <= j_r + 1'b1;
          end
          rd_last_r <= (j_r == n_r - 1'b1);
          if (rd_v_r) begin
            hit_r <= hit_fin;
            if (rd_last_r) begin
              if (!hit_fin) begin
                hc_r <= '0;
              end else if (hc_inc > {1'b0, cfg.full_hit_limit}) begin
                hc_r            <= '0;
                res_r.full_flag <= 1'b1;
              end else begin
                hc_r <= hc_inc[lcfcd_pkg::LIMIT_W-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/low_current_full_charge_detector_core.sv */
// Top level of the low-current full-charge detector: stream ports, APB registers
// and output register. Depends on lcfcd_pkg and lcfcd_seq.

// Each request carries one action: a sample, a start, or a write to the threshold,
// termination pair or pair count tables. One request is in work at a time and
// in_tready stays low until its result has been handed to the output register.
// A table write is stored and then passed on as a result. A start and a sample walk
// the thresholds, one threshold per cycle through the shared comparator; a sample
// then reads the pair RAM once per termination pair of the adopted region (at most
// 6). A sample in an invalid region, or in a region without pairs, skips the pair
// reads. A waiting result does not block the next request from starting. Registers:
// 0x0 region debounce limit, 0x4 full hit limit, both 4 bits.
module low_current_full_charge_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // temperature, cell_voltage, cell_current, table_region, table_slot, pair_count
  input  logic [lcfcd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [lcfcd_pkg::ACTION_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // full_flag, status_code, region_in_use
  output logic [lcfcd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  lcfcd_pkg::cfg_t    cfg_r;
  lcfcd_pkg::item_t   item;
  lcfcd_pkg::result_t res;
  logic               res_valid, res_ready;
  logic               out_valid_r;
  lcfcd_pkg::result_t out_r;
  logic               cfg_wr;
  lcfcd_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = lcfcd_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_debounce_limit <= lcfcd_pkg::DEBOUNCE_RESET;
      cfg_r.full_hit_limit        <= lcfcd_pkg::HIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcfcd_pkg::REG_DEBOUNCE: cfg_r.region_debounce_limit <= cfg_pwdata[3:0];
        lcfcd_pkg::REG_HIT:      cfg_r.full_hit_limit        <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lcfcd_pkg::REG_DEBOUNCE: cfg_prdata = {28'd0, cfg_r.region_debounce_limit};
      lcfcd_pkg::REG_HIT:      cfg_prdata = {28'd0, cfg_r.full_hit_limit};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    item.action       = in_tuser;
    item.temperature  = in_tdata[11:0];
    item.cell_voltage = in_tdata[27:12];
    item.cell_current = in_tdata[43:28];
    item.table_region = in_tdata[46:44];
    item.table_slot   = in_tdata[49:47];
    item.pair_count   = in_tdata[52:50];
  end

  lcfcd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_tvalid),
    .item       (item),
    .item_ready (in_tready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_r.region_in_use, out_r.status_code, out_r.full_flag};

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  a_full_needs_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("full flagged in an invalid region");

  a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[4:2] == 3'(lcfcd_pkg::NUM_REGIONS))
    else $error("invalid status with a valid region code");
`endif

endmodule

/* sim/low_current_full_charge_detector_core_test.sv */
// Testbench for low_current_full_charge_detector_core: a directed table, then random phases
// under several limit settings, every result checked against an in-bench prediction or,
// for typed directed rows, a given value. Depends on lcfcd_pkg and the core RTL.
module low_current_full_charge_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 78;
  localparam int NUM_PHASES   = 8;
  localparam int HIT_PCT      = 93;
  localparam int ACT_CODE_MAX = 7;
  localparam int FIELD3_MAX   = 7;
  localparam int TEMP_MIN     = -2048;
  localparam int TEMP_MAX     = 2047;
  localparam int CURR_MIN     = -32768;
  localparam int CURR_MAX     = 32767;
  localparam int VOLT_MAX     = 65535;
  localparam logic [lcfcd_pkg::FIELD3_W-1:0] RGN_NONE =
    lcfcd_pkg::FIELD3_W'(lcfcd_pkg::NUM_REGIONS);

  typedef struct {
    lcfcd_pkg::item_t   it;
    bit                 typed;
    lcfcd_pkg::result_t want;
  } dir_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [lcfcd_pkg::IN_TDATA_W-1:0]    in_tdata;
  logic [lcfcd_pkg::ACTION_W-1:0]      in_tuser;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [lcfcd_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [2:0]                          cfg_paddr;
  logic [31:0]                         cfg_pwdata;
  logic [31:0]                         cfg_prdata;
  logic                                cfg_pready;

  // detector state as predicted
  logic signed [lcfcd_pkg::TEMP_W-1:0] thr_tbl    [lcfcd_pkg::NUM_REGIONS+1];
  logic signed [lcfcd_pkg::CURR_W-1:0] ilim_tbl   [lcfcd_pkg::PAIR_SLOTS];
  logic [lcfcd_pkg::VOLT_W-1:0]        vlim_tbl   [lcfcd_pkg::PAIR_SLOTS];
  logic [lcfcd_pkg::FIELD3_W-1:0]      npairs_tbl [lcfcd_pkg::NUM_REGIONS];
  logic [lcfcd_pkg::FIELD3_W-1:0]      adopted_rgn;
  logic [lcfcd_pkg::FIELD3_W-1:0]      status_rgn;
  logic [lcfcd_pkg::LIMIT_W-1:0]       mism_cnt;
  logic [lcfcd_pkg::LIMIT_W-1:0]       hit_cnt;
  logic [lcfcd_pkg::LIMIT_W-1:0]       debounce_lim;
  logic [lcfcd_pkg::LIMIT_W-1:0]       hit_lim;

  bit                 pair_written [lcfcd_pkg::PAIR_SLOTS];
  lcfcd_pkg::result_t pending_results [$];
  dir_row_t           dir_rows [$];
  int                 mismatches = 0;
  int                 quiet = 0;
  int                 stall_left = 0;
  int                 aim_rgn = 0;
  bit                 idle_on = 1'b1;

  low_current_full_charge_detector_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_int(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic lcfcd_pkg::item_t make_item(int act, int temp, int volt, int curr,
                                                 int rgn, int slot, int cnt);
    lcfcd_pkg::item_t it;
    it.action       = lcfcd_pkg::ACTION_W'(act);
    it.temperature  = lcfcd_pkg::TEMP_W'(temp);
    it.cell_voltage = lcfcd_pkg::VOLT_W'(volt);
    it.cell_current = lcfcd_pkg::CURR_W'(curr);
    it.table_region = lcfcd_pkg::FIELD3_W'(rgn);
    it.table_slot   = lcfcd_pkg::FIELD3_W'(slot);
    it.pair_count   = lcfcd_pkg::FIELD3_W'(cnt);
    return it;
  endfunction

  function automatic logic [lcfcd_pkg::FIELD3_W-1:0] lookup_region(
      logic signed [lcfcd_pkg::TEMP_W-1:0] t);
    for (int i = 0; i < lcfcd_pkg::NUM_REGIONS; i++)
      if (t >= thr_tbl[i] && t < thr_tbl[i+1]) return lcfcd_pkg::FIELD3_W'(i);
    return RGN_NONE;
  endfunction

  function automatic int written_prefix(int rgn);
    int n;
    n = 0;
    while (n < lcfcd_pkg::PAIRS_PER_REGION &&
           pair_written[rgn*lcfcd_pkg::PAIRS_PER_REGION+n]) n++;
    return n;
  endfunction

  task automatic predict_charge(input lcfcd_pkg::item_t it, output lcfcd_pkg::result_t res);
    logic [lcfcd_pkg::FIELD3_W-1:0] r;
    int n, base, nxt, idx;
    bit hit;
    res = '0;
    case (it.action)
      lcfcd_pkg::ACT_SAMPLE: begin
        r = lookup_region(it.temperature);
        if (r != adopted_rgn) begin
          if (mism_cnt != lcfcd_pkg::COUNT_MAX) mism_cnt = mism_cnt + 1'b1;
          if (mism_cnt >= debounce_lim) begin
            adopted_rgn = r;
            status_rgn  = r;
            mism_cnt    = '0;
          end
        end
        if (status_rgn >= lcfcd_pkg::NUM_REGIONS) begin
          res.status_code = 1'b1;
        end else begin
          n = npairs_tbl[status_rgn];
          if (n > lcfcd_pkg::PAIRS_PER_REGION) n = lcfcd_pkg::PAIRS_PER_REGION;
          base = int'(status_rgn) * lcfcd_pkg::PAIRS_PER_REGION;
          hit = 1'b0;
          for (int i = 0; i < n; i++)
            if ($signed(it.cell_current) <= $signed(ilim_tbl[base+i]) &&
                it.cell_voltage >= vlim_tbl[base+i]) hit = 1'b1;
          if (hit) begin
            nxt = int'(hit_cnt) + 1;
            if (nxt > int'(hit_lim)) begin
              hit_cnt = '0;
              res.full_flag = 1'b1;
            end else begin
              hit_cnt = lcfcd_pkg::LIMIT_W'(nxt);
            end
          end else begin
            hit_cnt = '0;
          end
        end
      end
      lcfcd_pkg::ACT_START: begin
        status_rgn = lookup_region(it.temperature);
        hit_cnt = '0;
      end
      lcfcd_pkg::ACT_WR_THRESH: begin
        if (it.table_slot <= lcfcd_pkg::NUM_REGIONS) thr_tbl[it.table_slot] = it.temperature;
      end
      lcfcd_pkg::ACT_WR_PAIR: begin
        if (it.table_region < lcfcd_pkg::NUM_REGIONS &&
            it.table_slot < lcfcd_pkg::PAIRS_PER_REGION) begin
          idx = int'(it.table_region) * lcfcd_pkg::PAIRS_PER_REGION + int'(it.table_slot);
          ilim_tbl[idx] = it.cell_current;
          vlim_tbl[idx] = it.cell_voltage;
          pair_written[idx] = 1'b1;
        end
      end
      lcfcd_pkg::ACT_WR_COUNT: begin
        if (it.table_region < lcfcd_pkg::NUM_REGIONS)
          npairs_tbl[it.table_region] = it.pair_count;
      end
      default: ;
    endcase
    res.region_in_use = status_rgn;
  endtask

  task automatic send_req(input lcfcd_pkg::item_t it, input bit typed,
                          input lcfcd_pkg::result_t want);
    lcfcd_pkg::result_t guess;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {3'b000, it.pair_count, it.table_slot, it.table_region, it.cell_current,
                  it.cell_voltage, it.temperature};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_charge(it, guess);
    pending_results.push_back(typed ? want : guess);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_access(input lcfcd_pkg::reg_idx_t idx, input bit wr,
                            input logic [lcfcd_pkg::LIMIT_W-1:0] val,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    if (wr) begin
      if (idx == lcfcd_pkg::REG_DEBOUNCE) debounce_lim = val;
      else hit_lim = val;
    end
  endtask

  task automatic check_reg(input lcfcd_pkg::reg_idx_t idx);
    logic [31:0] rd;
    logic [lcfcd_pkg::LIMIT_W-1:0] want;
    want = (idx == lcfcd_pkg::REG_DEBOUNCE) ? debounce_lim : hit_lim;
    reg_access(idx, 1'b0, '0, rd);
    if (rd !== 32'(want)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back: expected %0d, got %0h", idx, want, rd);
    end
  endtask

  task automatic load_limits(input logic [lcfcd_pkg::LIMIT_W-1:0] deb,
                             input logic [lcfcd_pkg::LIMIT_W-1:0] hits);
    logic [31:0] rd;
    reg_access(lcfcd_pkg::REG_DEBOUNCE, 1'b1, deb, rd);
    check_reg(lcfcd_pkg::REG_DEBOUNCE);
    reg_access(lcfcd_pkg::REG_HIT, 1'b1, hits, rd);
    check_reg(lcfcd_pkg::REG_HIT);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic add_row(input lcfcd_pkg::item_t it, input bit typed,
                         input lcfcd_pkg::result_t want);
    dir_row_t row;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic lcfcd_pkg::item_t gen_sample();
    int lo, hi, t, c, v, n, p, base;
    if ($urandom_range(0, 99) < 8) aim_rgn = $urandom_range(0, lcfcd_pkg::NUM_REGIONS);
    lo = 0;
    hi = 0;
    if (aim_rgn < lcfcd_pkg::NUM_REGIONS) begin
      lo = thr_tbl[aim_rgn];
      hi = thr_tbl[aim_rgn+1];
    end
    if (aim_rgn < lcfcd_pkg::NUM_REGIONS && lo < hi && $urandom_range(0, 99) < 85)
      t = rand_int(lo, hi - 1);
    else if ($urandom_range(0, 9) == 0)
      t = $urandom_range(0, 1) ? TEMP_MIN : TEMP_MAX;
    else
      t = rand_int(TEMP_MIN, TEMP_MAX);
    n = 0;
    if (status_rgn < lcfcd_pkg::NUM_REGIONS) begin
      n = npairs_tbl[status_rgn];
      if (n > lcfcd_pkg::PAIRS_PER_REGION) n = lcfcd_pkg::PAIRS_PER_REGION;
    end
    if (n > 0 && $urandom_range(0, 99) < HIT_PCT) begin
      base = int'(status_rgn) * lcfcd_pkg::PAIRS_PER_REGION;
      p = rand_int(0, n - 1);
      c = rand_int(CURR_MIN, int'(ilim_tbl[base+p]));
      v = rand_int(int'(vlim_tbl[base+p]), VOLT_MAX);
    end else begin
      c = rand_int(CURR_MIN, CURR_MAX);
      v = rand_int(0, VOLT_MAX);
    end
    return make_item(lcfcd_pkg::ACT_SAMPLE, t, v, c, rand_int(0, FIELD3_MAX),
                     rand_int(0, FIELD3_MAX), rand_int(0, FIELD3_MAX));
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lcfcd_pkg::result_t got, exp_res;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.full_flag     = out_tdata[0];
      got.status_code   = out_tdata[1];
      got.region_in_use = out_tdata[4:2];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: full=%0d status=%0d region=%0d",
                   got.full_flag, got.status_code, got.region_in_use);
      end else begin
        exp_res = pending_results.pop_front();
        if (got.full_flag !== exp_res.full_flag || got.status_code !== exp_res.status_code ||
            got.region_in_use !== exp_res.region_in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected full=%0d status=%0d region=%0d, got %0d %0d %0d",
                     exp_res.full_flag, exp_res.status_code, exp_res.region_in_use,
                     got.full_flag, got.status_code, got.region_in_use);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1) || cfg_psel === 1'b1) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int deb_set [NUM_PHASES];
    int hit_set [NUM_PHASES];
    int sent, pick, t, r, s, c, p;
    lcfcd_pkg::result_t idle_res, inv_res, start_res, none_res;
    lcfcd_pkg::item_t it;

    deb_set = '{1, 15, 0, 2, 0, 4, 15, 0};
    hit_set = '{0, 15, 3, 6, 0, 1, 0, 15};
    deb_set[4] = $urandom_range(0, 15);
    hit_set[4] = $urandom_range(0, 15);

    for (int i = 0; i < lcfcd_pkg::NUM_REGIONS; i++) npairs_tbl[i] = '0;
    for (int i = 0; i < lcfcd_pkg::PAIR_SLOTS; i++) pair_written[i] = 1'b0;
    adopted_rgn  = RGN_NONE;
    status_rgn   = RGN_NONE;
    mism_cnt     = '0;
    hit_cnt      = '0;
    debounce_lim = lcfcd_pkg::DEBOUNCE_RESET;
    hit_lim      = lcfcd_pkg::HIT_RESET;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= lcfcd_pkg::ACT_SAMPLE;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reg(lcfcd_pkg::REG_DEBOUNCE);
    check_reg(lcfcd_pkg::REG_HIT);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;

    idle_res  = '{full_flag: 1'b0, status_code: 1'b0, region_in_use: RGN_NONE};
    inv_res   = '{full_flag: 1'b0, status_code: 1'b1, region_in_use: RGN_NONE};
    start_res = '{full_flag: 1'b0, status_code: 1'b0, region_in_use: 3'd2};
    none_res  = '0;

    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, TEMP_MIN, 0, 0, 0, 0, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, -200, 0, 0, 0, 1, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, 0, 0, 0, 0, 2, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, 150, 0, 0, 0, 3, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, 300, 0, 0, 0, 4, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, 450, 0, 0, 0, 5, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, TEMP_MAX, 0, 0, 0, 6, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_THRESH, 1000, 0, 0, 0, 7, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_PAIR, 0, 4200, 500, 2, 0, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_PAIR, 0, VOLT_MAX, CURR_MIN, 2, 1, 0), 1'b1,
            idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_PAIR, 0, 0, CURR_MAX, 3, 0, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_PAIR, 0, 100, 100, 6, 0, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_PAIR, 0, 100, 100, 0, 7, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_COUNT, 0, 0, 0, 2, 0, 2), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_COUNT, 0, 0, 0, 3, 0, 1), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_COUNT, 0, 0, 0, 7, 0, 7), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_WR_COUNT + 1, 0, 0, 0, 0, 0, 0), 1'b1, idle_res);
    add_row(make_item(ACT_CODE_MAX, 0, 0, 0, 0, 0, 0), 1'b1, idle_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, TEMP_MAX, 0, 0, 0, 0, 0), 1'b1, inv_res);
    add_row(make_item(lcfcd_pkg::ACT_START, 100, 0, 0, 0, 0, 0), 1'b1, start_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, 100, 4200, 500, 0, 0, 0), 1'b0, none_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, 149, 4199, 501, 0, 0, 0), 1'b0, none_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, TEMP_MIN, 0, 0, 0, 0, 0), 1'b0, none_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, 200, 0, CURR_MAX, 0, 0, 0), 1'b0, none_res);
    add_row(make_item(lcfcd_pkg::ACT_SAMPLE, 2046, 0, 0, 0, 0, 0), 1'b0, none_res);
    add_row(make_item(lcfcd_pkg::ACT_START, TEMP_MAX, 0, 0, 0, 0, 0), 1'b0, none_res);

    foreach (dir_rows[i]) send_req(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_tvalid <= 1'b0;
      drain_results();
      idle_on = (ph < NUM_PHASES - 1);
      load_limits(lcfcd_pkg::LIMIT_W'(deb_set[ph]), lcfcd_pkg::LIMIT_W'(hit_set[ph]));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          t = $urandom_range(0, 1) ? TEMP_MIN : rand_int(TEMP_MIN, -1000);
          for (s = 0; s <= lcfcd_pkg::NUM_REGIONS; s++) begin
            if (s == lcfcd_pkg::NUM_REGIONS && $urandom_range(0, 1)) t = TEMP_MAX;
            send_req(make_item(lcfcd_pkg::ACT_WR_THRESH, t, rand_int(0, VOLT_MAX),
                               rand_int(CURR_MIN, CURR_MAX), rand_int(0, FIELD3_MAX), s,
                               rand_int(0, FIELD3_MAX)), 1'b0, none_res);
            t = t + rand_int(1, 600);
            if (t > TEMP_MAX) t = TEMP_MAX;
            sent++;
          end
        end else if (pick < 7) begin
          send_req(make_item(lcfcd_pkg::ACT_WR_THRESH, rand_int(TEMP_MIN, TEMP_MAX),
                             rand_int(0, VOLT_MAX), rand_int(CURR_MIN, CURR_MAX),
                             rand_int(0, FIELD3_MAX), rand_int(0, FIELD3_MAX),
                             rand_int(0, FIELD3_MAX)), 1'b0, none_res);
          sent++;
        end else if (pick < 10) begin
          r = rand_int(0, lcfcd_pkg::NUM_REGIONS - 1);
          for (s = 0; s < lcfcd_pkg::PAIRS_PER_REGION; s++) begin
            send_req(make_item(lcfcd_pkg::ACT_WR_PAIR, rand_int(TEMP_MIN, TEMP_MAX),
                               rand_int(0, VOLT_MAX), rand_int(CURR_MIN, CURR_MAX), r, s,
                               rand_int(0, FIELD3_MAX)), 1'b0, none_res);
            sent++;
          end
          c = $urandom_range(0, 1) ? FIELD3_MAX : lcfcd_pkg::PAIRS_PER_REGION;
          send_req(make_item(lcfcd_pkg::ACT_WR_COUNT, rand_int(TEMP_MIN, TEMP_MAX),
                             rand_int(0, VOLT_MAX), rand_int(CURR_MIN, CURR_MAX), r,
                             rand_int(0, FIELD3_MAX), c), 1'b0, none_res);
          sent++;
        end else if (pick < 16) begin
          r = ($urandom_range(0, 4) == 0) ? rand_int(0, FIELD3_MAX)
                                          : rand_int(0, lcfcd_pkg::NUM_REGIONS - 1);
          s = ($urandom_range(0, 4) == 0) ? rand_int(0, FIELD3_MAX)
                                          : rand_int(0, lcfcd_pkg::PAIRS_PER_REGION - 1);
          send_req(make_item(lcfcd_pkg::ACT_WR_PAIR, rand_int(TEMP_MIN, TEMP_MAX),
                             rand_int(0, VOLT_MAX), rand_int(CURR_MIN, CURR_MAX), r, s,
                             rand_int(0, FIELD3_MAX)), 1'b0, none_res);
          sent++;
        end else if (pick < 20) begin
          r = rand_int(0, FIELD3_MAX);
          if (r < lcfcd_pkg::NUM_REGIONS) begin
            p = written_prefix(r);
            c = (p == lcfcd_pkg::PAIRS_PER_REGION && $urandom_range(0, 2) == 0)
                ? FIELD3_MAX : rand_int(0, p);
          end else begin
            c = rand_int(0, FIELD3_MAX);
          end
          send_req(make_item(lcfcd_pkg::ACT_WR_COUNT, rand_int(TEMP_MIN, TEMP_MAX),
                             rand_int(0, VOLT_MAX), rand_int(CURR_MIN, CURR_MAX), r,
                             rand_int(0, FIELD3_MAX), c), 1'b0, none_res);
          sent++;
        end else if (pick < 25) begin
          it = gen_sample();
          it.action = lcfcd_pkg::ACT_START;
          send_req(it, 1'b0, none_res);
          sent++;
        end else if (pick < 27) begin
          send_req(make_item(rand_int(lcfcd_pkg::ACT_WR_COUNT + 1, ACT_CODE_MAX),
                             rand_int(TEMP_MIN, TEMP_MAX), rand_int(0, VOLT_MAX),
                             rand_int(CURR_MIN, CURR_MAX), rand_int(0, FIELD3_MAX),
                             rand_int(0, FIELD3_MAX), rand_int(0, FIELD3_MAX)),
                   1'b0, none_res);
        end else begin
          send_req(gen_sample(), 1'b0, none_res);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/lcfcd_pkg.sv
hdl/lcfcd_ram.sv
hdl/lcfcd_cmp.sv
hdl/lcfcd_seq.sv
hdl/low_current_full_charge_detector_core.sv
sim/low_current_full_charge_detector_core_test.sv
